// ===== hw/rtl/mtsg_pkg.sv =====
// Shared word types and constants for the multirate tick strobe generator.
package mtsg_pkg;

  localparam logic [1:0] PHASE_ZERO = 2'd0;
  localparam logic [1:0] PHASE_POS  = 2'd1;
  localparam logic [1:0] PHASE_NEG  = 2'd2;

  localparam logic [15:0] GRID_TIMEOUT_RST = 16'd1000;
  localparam logic [15:0] BUCK_MS_MAX      = 16'hffff;

  localparam int DIV_FAST   = 10;
  localparam int DIV_120    = 5;
  localparam int DIV_60     = 10;
  localparam int DIV_MS     = 6;
  localparam int DIV_100    = 10;
  localparam int DIV_TEMP   = 51;
  localparam int DIV_10     = 10;
  localparam int DIV_START  = 10;
  localparam int DIV_2      = 5;
  localparam int DIV_1      = 10;
  localparam int DIV_RUNSEC = 1000;

  typedef struct packed {
    logic zero_cross_pin;
    logic phase_pin;
    logic buck_enable;
    logic inverter_running;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  phase_class;
    logic        strobe_120hz;
    logic        strobe_60hz;
    logic        strobe_100hz;
    logic        strobe_10hz;
    logic        strobe_2hz;
    logic        strobe_1hz;
    logic        run_second;
    logic        grid_timeout;
    logic        temperature_due;
    logic        start_second;
    logic [15:0] buck_run_ms;
  } out_word_t;

endpackage

// ===== hw/rtl/mtsg_div.sv =====
// Wrap-to-zero divide counter with a terminal-count strobe.
module mtsg_div #(
  parameter int LIMIT = 10
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  output logic tick
);

  localparam int CW = (LIMIT > 1) ? $clog2(LIMIT) : 1;
  localparam logic [CW-1:0] LAST = CW'(LIMIT - 1);

  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;

  assign tick = en && (cnt_r == LAST);

  always_comb begin
    cnt_nxt = cnt_r;
    if (tick) begin
      cnt_nxt = '0;
    end else if (en) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/multirate_tick_strobe_generator_top.sv =====
// Top level: divider tree, grid timer, buck run counter and output skid stage.
//
//   channel | direction | handshake           | data
//   in_     | input     | in_valid / in_stall  | in_word (in_word_t), one tick
//   out_    | output    | out_valid / out_stall| out_word (out_word_t)
//   cfg_    | input     | cfg_valid / cfg_ready| cfg_data, grid timeout in ms
//
// One word per clock while in_stall is low; the result is registered.
// All counters update in the accepting cycle, so throughput is set only by the
// two-entry output stage: in_stall rises once both output and skid hold words.
// rst_n is synchronous; it clears all counters, the grid timeout to 1000 ms
// and the output valids. cfg_ready is always high.
module multirate_tick_strobe_generator_top #(
  parameter int GRID_TIMER_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mtsg_pkg::in_word_t in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output mtsg_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  import mtsg_pkg::*;

  localparam int CMP_W = (GRID_TIMER_BITS > 16) ? GRID_TIMER_BITS : 16;

  logic        accept;
  logic        fast_tick, ms_tick, s100_tick, s10_tick;
  logic        buck_go;
  logic [1:0]  phase_cls;
  logic        s120_tick, s60_tick, temp_tick, start_tick, s2_tick, s1_tick;
  logic        runsec_tick, grid_to;
  out_word_t   res;

  logic [15:0]                grid_timeout_r;
  logic [GRID_TIMER_BITS-1:0] grid_ms_r, grid_ms_nxt, grid_inc;
  logic [15:0]                buck_ms_r, buck_ms_nxt;

  out_word_t out_word_r, skid_word_r;
  logic      out_valid_r, skid_valid_r;
  logic      out_take;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = skid_valid_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_take  = out_valid_r && !out_stall;

  // Divider tree
  mtsg_div #(.LIMIT(DIV_FAST)) u_fast (.clk, .rst_n, .en(accept), .tick(fast_tick));
  mtsg_div #(.LIMIT(DIV_120)) u_120 (.clk, .rst_n, .en(fast_tick), .tick(s120_tick));
  mtsg_div #(.LIMIT(DIV_60)) u_60 (.clk, .rst_n, .en(fast_tick), .tick(s60_tick));
  mtsg_div #(.LIMIT(DIV_MS)) u_ms (.clk, .rst_n, .en(accept), .tick(ms_tick));
  mtsg_div #(.LIMIT(DIV_100)) u_100 (.clk, .rst_n, .en(ms_tick), .tick(s100_tick));
  mtsg_div #(.LIMIT(DIV_TEMP)) u_temp (.clk, .rst_n, .en(s100_tick), .tick(temp_tick));
  mtsg_div #(.LIMIT(DIV_10)) u_10 (.clk, .rst_n, .en(s100_tick), .tick(s10_tick));
  mtsg_div #(.LIMIT(DIV_START)) u_start (.clk, .rst_n, .en(s10_tick), .tick(start_tick));
  mtsg_div #(.LIMIT(DIV_2)) u_2 (.clk, .rst_n, .en(s10_tick), .tick(s2_tick));
  mtsg_div #(.LIMIT(DIV_1)) u_1 (.clk, .rst_n, .en(s10_tick), .tick(s1_tick));

  // Run-second divider only advances while the buck is enabled and running
  assign buck_go = ms_tick && in_word.buck_enable && in_word.inverter_running;
  mtsg_div #(.LIMIT(DIV_RUNSEC)) u_runsec (.clk, .rst_n, .en(buck_go),
                                           .tick(runsec_tick));

  always_comb begin
    if (in_word.zero_cross_pin) begin
      phase_cls = PHASE_ZERO;
    end else if (in_word.phase_pin) begin
      phase_cls = PHASE_NEG;
    end else begin
      phase_cls = PHASE_POS;
    end
  end

  // Grid timer: wraps in its own width, compared after increment
  assign grid_inc = grid_ms_r + 1'b1;

  always_comb begin
    grid_ms_nxt = grid_ms_r;
    grid_to     = 1'b0;
    if (ms_tick) begin
      if (CMP_W'(grid_inc) >= CMP_W'(grid_timeout_r)) begin
        grid_ms_nxt = '0;
        grid_to     = 1'b1;
      end else begin
        grid_ms_nxt = grid_inc;
      end
    end
  end

  always_comb begin
    buck_ms_nxt = buck_ms_r;
    if (buck_go && (buck_ms_r != BUCK_MS_MAX)) begin
      buck_ms_nxt = buck_ms_r + 16'd1;
    end
  end

  // Fields in out_word_t order
  assign res = {phase_cls, s120_tick, s60_tick, s100_tick, s10_tick, s2_tick, s1_tick,
                runsec_tick, grid_to, temp_tick, start_tick, buck_ms_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_timeout_r <= GRID_TIMEOUT_RST;
      grid_ms_r      <= '0;
      buck_ms_r      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        grid_timeout_r <= cfg_data;
      end
      grid_ms_r <= grid_ms_nxt;
      buck_ms_r <= buck_ms_nxt;
    end
  end

  // Output register plus skid word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (out_take) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end
      end else if (accept) begin
        if (out_valid_r && !out_take) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_word_r <= skid_word_r;
      end
    end else if (accept) begin
      if (out_valid_r && !out_take) begin
        skid_word_r <= res;
      end else begin
        out_word_r <= res;
      end
    end
  end

endmodule

// ===== bench/tb_multirate_tick_strobe_generator_top.sv =====
// Self-checking bench for the multirate tick strobe generator: directed ticks, then random ticks.
`timescale 1ns / 100ps

module tb_multirate_tick_strobe_generator_top;
  import mtsg_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_TICKS    = 150;
  localparam int NUM_PHASES     = 6;

  // Running model of the dividers, grid timer and buck counter, plus the words the block owes.
  class tick_strobe_checker;
    logic [15:0] grid_timeout_ms;
    int          fast_div;
    int          div_120;
    int          div_60;
    int          ms_div;
    logic [15:0] buck_ms;
    int          buck_sec_div;
    logic [15:0] grid_ms;
    int          div_100;
    logic [5:0]  temp_periods;
    int          div_10;
    int          decade;
    int          div_2;
    int          div_1;
    out_word_t   expected_words[$];
    int          errors;

    function new();
      grid_timeout_ms = GRID_TIMEOUT_RST;
      fast_div = 0; div_120 = 0; div_60 = 0; ms_div = 0;
      buck_ms = '0; buck_sec_div = 0; grid_ms = '0;
      div_100 = 0; temp_periods = '0; div_10 = 0;
      decade = 0; div_2 = 0; div_1 = 0;
      errors = 0;
    endfunction

    function void set_grid_timeout(logic [15:0] ms);
      grid_timeout_ms = ms;
    endfunction

    // wrap-to-zero divider, true on the wrap
    function bit divide(inout int cnt, input int limit);
      cnt = cnt + 1;
      if (cnt >= limit) begin
        cnt = 0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function out_word_t predict_strobes(in_word_t w);
      out_word_t r;
      int c;
      r = '0;
      if (w.zero_cross_pin) r.phase_class = PHASE_ZERO;
      else if (w.phase_pin) r.phase_class = PHASE_NEG;
      else r.phase_class = PHASE_POS;

      c = fast_div;
      if (divide(c, DIV_FAST)) begin
        fast_div = c;
        c = div_120; r.strobe_120hz = divide(c, DIV_120); div_120 = c;
        c = div_60;  r.strobe_60hz  = divide(c, DIV_60);  div_60  = c;
      end else begin
        fast_div = c;
      end

      c = ms_div;
      r.buck_run_ms = buck_ms;
      if (divide(c, DIV_MS)) begin
        ms_div = c;
        if (w.buck_enable && w.inverter_running) begin
          if (buck_ms != BUCK_MS_MAX) buck_ms = buck_ms + 16'd1;
          c = buck_sec_div; r.run_second = divide(c, DIV_RUNSEC); buck_sec_div = c;
        end
        grid_ms = grid_ms + 16'd1;
        if (grid_ms >= grid_timeout_ms) begin
          grid_ms = '0;
          r.grid_timeout = 1'b1;
        end
        c = div_100;
        if (divide(c, DIV_100)) begin
          div_100 = c;
          r.strobe_100hz = 1'b1;
          if (temp_periods >= DIV_TEMP - 1) begin
            temp_periods = '0;
            r.temperature_due = 1'b1;
          end else begin
            temp_periods = temp_periods + 6'd1;
          end
          c = div_10;
          if (divide(c, DIV_10)) begin
            div_10 = c;
            r.strobe_10hz = 1'b1;
            c = decade; r.start_second = divide(c, DIV_START); decade = c;
            c = div_2;  r.strobe_2hz   = divide(c, DIV_2);     div_2  = c;
            c = div_1;  r.strobe_1hz   = divide(c, DIV_1);     div_1  = c;
          end else begin
            div_10 = c;
          end
        end else begin
          div_100 = c;
        end
      end else begin
        ms_div = c;
      end
      r.buck_run_ms = buck_ms;
      return r;
    endfunction

    function void note_tick(in_word_t w);
      expected_words.push_back(predict_strobes(w));
    endfunction

    function void check_field(string name, logic [15:0] exp, logic [15:0] got);
      if (exp != got) begin
        $error("%s: expected %0d, got %0d", name, exp, got);
        errors++;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t exp;
      if (expected_words.size() == 0) begin
        $error("output word with nothing expected: %h", got);
        errors++;
        return;
      end
      exp = expected_words.pop_front();
      check_field("phase_class", 16'(exp.phase_class), 16'(got.phase_class));
      check_field("strobe_120hz", 16'(exp.strobe_120hz), 16'(got.strobe_120hz));
      check_field("strobe_60hz", 16'(exp.strobe_60hz), 16'(got.strobe_60hz));
      check_field("strobe_100hz", 16'(exp.strobe_100hz), 16'(got.strobe_100hz));
      check_field("strobe_10hz", 16'(exp.strobe_10hz), 16'(got.strobe_10hz));
      check_field("strobe_2hz", 16'(exp.strobe_2hz), 16'(got.strobe_2hz));
      check_field("strobe_1hz", 16'(exp.strobe_1hz), 16'(got.strobe_1hz));
      check_field("run_second", 16'(exp.run_second), 16'(got.run_second));
      check_field("grid_timeout", 16'(exp.grid_timeout), 16'(got.grid_timeout));
      check_field("temperature_due", 16'(exp.temperature_due), 16'(got.temperature_due));
      check_field("start_second", 16'(exp.start_second), 16'(got.start_second));
      check_field("buck_run_ms", exp.buck_run_ms, got.buck_run_ms);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  tick_strobe_checker sb = new();
  int sender_idle_pct = 10;
  int receiver_stall_pct = 65;
  int idle_cycles = 0;

  multirate_tick_strobe_generator_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < receiver_stall_pct);
  end

  // monitor: feeds the model, checks words, and runs the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_grid_timeout(cfg_data);
      if (in_valid && !in_stall) sb.note_tick(in_word);
      if (out_valid && !out_stall) sb.check_word(out_word);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_multirate_tick_strobe_generator_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_tick(in_word_t w);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_grid_timeout(logic [15:0] ms);
    cfg_valid <= 1'b1;
    cfg_data  <= ms;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly a running buck with live pins; the rest is fully random
  function automatic in_word_t random_tick();
    in_word_t w;
    if ($urandom_range(99) < 75) begin
      w.zero_cross_pin   = ($urandom_range(3) == 0);
      w.phase_pin        = 1'($urandom_range(1));
      w.buck_enable      = 1'b1;
      w.inverter_running = 1'b1;
    end else begin
      w = in_word_t'(4'($urandom_range(15)));
    end
    return w;
  endfunction

  initial begin
    logic [15:0] timeouts[NUM_PHASES];
    timeouts[0] = 16'd0;
    timeouts[1] = 16'hffff;
    timeouts[2] = 16'd1;
    timeouts[3] = 16'd7;
    timeouts[4] = 16'($urandom_range(20, 2));
    timeouts[5] = 16'($urandom_range(65535));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every pin combination, then a run of buck-active ticks, at reset timeout
    for (int i = 0; i < 16; i++) send_tick(in_word_t'(4'(i)));
    for (int i = 0; i < 8; i++) send_tick(in_word_t'(4'b0011));
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p / 2)
        0: begin
          sender_idle_pct = 10;
          receiver_stall_pct = 65;
        end
        1: begin
          sender_idle_pct = 65;
          receiver_stall_pct = 10;
        end
        default: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
      endcase
      write_grid_timeout(timeouts[p]);
      for (int i = 0; i < PHASE_TICKS; i++) begin
        // hold off mid-phase until the output side has caught up
        if (p == 3 && i == PHASE_TICKS / 2) wait_drained();
        send_tick(random_tick());
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_multirate_tick_strobe_generator_top: PASS");
    end else begin
      $display("tb_multirate_tick_strobe_generator_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mtsg_pkg.sv
hw/rtl/mtsg_div.sv
hw/rtl/multirate_tick_strobe_generator_top.sv
bench/tb_multirate_tick_strobe_generator_top.sv
